@@ src/mrpt_pkg.sv @@
`default_nettype none

package mrpt_pkg;

	// operand width of the datapath
	localparam int VALUE_WIDTH = 62;
	// width of the squaring exponent k (k < VALUE_WIDTH)
	localparam int K_WIDTH = $clog2(VALUE_WIDTH);

	localparam int BASE_COUNT_WIDTH = 4;
	localparam logic [BASE_COUNT_WIDTH-1:0] BASE_TABLE_SIZE = 4'd12;
	localparam logic [BASE_COUNT_WIDTH-1:0] BASE_COUNT_RESET = 4'd10;

	localparam int WITNESS_WIDTH = 6;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// status of the shared modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mrpt_mul_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPLIT,
		S_BASE,
		S_POW,
		S_POW_MUL,
		S_POW_SQ,
		S_CHECK,
		S_SQR_TEST,
		S_SQR_WAIT,
		S_DONE
	} mrpt_state_t;

	// small prime witnesses
	function automatic logic [WITNESS_WIDTH-1:0] witness(input logic [BASE_COUNT_WIDTH-1:0] idx);
		logic [WITNESS_WIDTH-1:0] w;
		case (idx)
			4'd0: w = 6'd2;
			4'd1: w = 6'd3;
			4'd2: w = 6'd5;
			4'd3: w = 6'd7;
			4'd4: w = 6'd11;
			4'd5: w = 6'd13;
			4'd6: w = 6'd17;
			4'd7: w = 6'd19;
			4'd8: w = 6'd23;
			4'd9: w = 6'd29;
			4'd10: w = 6'd31;
			4'd11: w = 6'd37;
			default: w = 6'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ src/mrpt_mulmod.sv @@
`default_nettype none

module mrpt_mulmod import mrpt_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire value_t         op_a,
	input  wire value_t         op_b,
	input  wire value_t         modulus,
	output mrpt_mul_stat_t      stat,
	output value_t              product
);

	value_t acc_q;
	value_t addend_q;
	value_t mult_q;
	logic   busy_q;

	logic [VALUE_WIDTH:0] acc_sum;
	logic [VALUE_WIDTH:0] dbl;
	value_t               acc_next;
	value_t               addend_next;

	// one compare-subtract suffices since both terms are below the modulus
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, addend_q};
		dbl     = {addend_q, 1'b0};
		if (acc_sum >= {1'b0, modulus}) begin
			acc_sum = acc_sum - {1'b0, modulus};
		end
		if (dbl >= {1'b0, modulus}) begin
			dbl = dbl - {1'b0, modulus};
		end
		acc_next    = mult_q[0] ? acc_sum[VALUE_WIDTH-1:0] : acc_q;
		addend_next = dbl[VALUE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && mult_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			addend_q <= op_a;
			mult_q   <= op_b;
		end else if (busy_q && mult_q != '0) begin
			acc_q    <= acc_next;
			addend_q <= addend_next;
			mult_q   <= mult_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && mult_q == '0;
	assign product   = acc_q;

endmodule

`default_nettype wire

@@ src/miller_rabin_primality_test_core.sv @@
`default_nettype none

// miller-rabin primality test core
//
// input: pulse start with candidate while busy is low; that edge takes the beat.
// busy stays high until the answer has been shown. output: done is high for
// exactly one cycle with is_prime valid; the receiver cannot stall, so the
// answer must be captured in that cycle. the user writes base_count through
// base_count_wr_en / base_count_wr_data only while idle (unchecked by the core);
// values above 12 use the whole witness table, zero tests no witness.
//
// sequence: trivial candidates (below 2, 2, even) answer in the cycle right after
// the start beat. odd candidates first shift out the factors of two of n-1 (one
// bit a cycle), then per witness run a^d mod n and up to k squarings. every
// modular product goes through one bit-serial shift-and-add multiplier. one
// candidate is handled at a time.
//
// reset: arst_n clears the sequencer to idle and base_count to 10.

module miller_rabin_primality_test_core import mrpt_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [VALUE_WIDTH-1:0]      candidate,
	output logic                             done,
	output logic                             is_prime,
	input  wire logic                        base_count_wr_en,
	input  wire logic [BASE_COUNT_WIDTH-1:0] base_count_wr_data
);

	mrpt_state_t state_q, state_nxt;

	logic [BASE_COUNT_WIDTH-1:0] base_count_q;
	logic [BASE_COUNT_WIDTH-1:0] idx_q;
	logic [K_WIDTH-1:0]          k_q;
	logic [K_WIDTH-1:0]          j_q;
	value_t                      n_q;
	value_t                      d_q;
	value_t                      e_q;
	value_t                      res_q;
	value_t                      sq_q;
	logic                        prime_q;

	// multiplier hookup
	logic           mul_start;
	value_t         mul_a;
	value_t         mul_b;
	value_t         mul_p;
	mrpt_mul_stat_t mul_stat;

	logic [BASE_COUNT_WIDTH-1:0] limit;
	value_t                      wit;
	value_t                      n_m1;
	logic                        accept;

	assign accept = start && !busy;
	assign limit  = (base_count_q > BASE_TABLE_SIZE) ? BASE_TABLE_SIZE : base_count_q;
	assign wit    = VALUE_WIDTH'(witness(idx_q));
	assign n_m1   = n_q - 1'b1;

	mrpt_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.modulus (n_q),
		.stat    (mul_stat),
		.product (mul_p)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					// below 2, exactly 2 and even values answer at once
					if (candidate < VALUE_WIDTH'(3) || !candidate[0]) begin
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_SPLIT;
					end
				end
			end
			S_SPLIT: begin
				if (d_q[0]) begin
					state_nxt = S_BASE;
				end
			end
			S_BASE: begin
				// out of witnesses, or witness not below n: prime
				if (idx_q >= limit || wit >= n_q) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_POW;
				end
			end
			S_POW: begin
				if (e_q == '0) begin
					state_nxt = S_CHECK;
				end else if (e_q[0]) begin
					state_nxt = S_POW_MUL;
				end else begin
					state_nxt = S_POW_SQ;
				end
			end
			S_POW_MUL: begin
				if (mul_stat.done) begin
					state_nxt = S_POW_SQ;
				end
			end
			S_POW_SQ: begin
				if (mul_stat.done) begin
					state_nxt = S_POW;
				end
			end
			S_CHECK: begin
				if (res_q == VALUE_WIDTH'(1)) begin
					state_nxt = S_BASE;
				end else begin
					state_nxt = S_SQR_TEST;
				end
			end
			S_SQR_TEST: begin
				if (j_q == k_q) begin
					state_nxt = S_DONE;
				end else if (res_q == n_m1) begin
					state_nxt = S_BASE;
				end else begin
					state_nxt = S_SQR_WAIT;
				end
			end
			S_SQR_WAIT: begin
				if (mul_stat.done) begin
					state_nxt = S_SQR_TEST;
				end
			end
			S_DONE: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		busy      = state_q != S_IDLE;
		done      = state_q == S_DONE;
		is_prime  = prime_q;
		mul_start = 1'b0;
		mul_a     = sq_q;
		mul_b     = sq_q;
		case (state_q)
			S_POW: begin
				// multiply into the result first when the exponent bit is set
				mul_start = e_q != '0;
				if (e_q[0]) begin
					mul_a = res_q;
				end
			end
			S_POW_MUL: begin
				mul_start = mul_stat.done;
			end
			S_SQR_TEST: begin
				mul_start = j_q != k_q && res_q != n_m1;
				mul_a     = res_q;
				mul_b     = res_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_count_q <= BASE_COUNT_RESET;
		end else begin
			state_q <= state_nxt;
			if (base_count_wr_en) begin
				base_count_q <= base_count_wr_data;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					n_q     <= candidate;
					d_q     <= candidate - 1'b1;
					k_q     <= '0;
					idx_q   <= '0;
					prime_q <= candidate == VALUE_WIDTH'(2);
				end
			end
			S_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			S_BASE: begin
				res_q   <= VALUE_WIDTH'(1);
				sq_q    <= wit;
				e_q     <= d_q;
				prime_q <= 1'b1;
			end
			S_POW_MUL: begin
				if (mul_stat.done) begin
					res_q <= mul_p;
				end
			end
			S_POW_SQ: begin
				if (mul_stat.done) begin
					sq_q <= mul_p;
					e_q  <= e_q >> 1;
				end
			end
			S_CHECK: begin
				j_q <= '0;
				if (res_q == VALUE_WIDTH'(1)) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SQR_TEST: begin
				if (j_q == k_q) begin
					prime_q <= 1'b0;
				end else if (res_q == n_m1) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			S_SQR_WAIT: begin
				if (mul_stat.done) begin
					res_q <= mul_p;
				end
			end
			default: begin
				prime_q <= prime_q;
			end
		endcase
	end

	// the sequencer never restarts the multiplier mid-product
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> (!mul_stat.busy || mul_stat.done))
		else $error("multiplier restarted while busy");

	// squaring loop works on a residue of n
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQR_TEST |-> res_q < n_q)
		else $error("residue not reduced");

	// the answer strobe is a single beat and is followed by idle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done strobe longer than one cycle");

	// an accepted candidate always makes the core busy
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted candidate did not raise busy");

endmodule

`default_nettype wire

@@ tb/sv/tb_miller_rabin_primality_test_core.sv @@
module tb_miller_rabin_primality_test_core;
	import mrpt_pkg::*;

	// witness primes in table order, entry 0 is the first base tried
	localparam logic [11:0][5:0] WITNESS_LIST = {
		6'd37, 6'd31, 6'd29, 6'd23, 6'd19, 6'd17,
		6'd13, 6'd11, 6'd7, 6'd5, 6'd3, 6'd2
	};

	// slowest candidate: every table base, a full power chain plus k squarings,
	// each product through the bit-serial multiplier, plus the widest sender gap
	localparam longint ITEM_CYCLES_MAX =
		longint'(BASE_TABLE_SIZE) * 3 * VALUE_WIDTH * (VALUE_WIDTH + 3) + 2 * VALUE_WIDTH + 256;
	localparam longint CYCLE_LIMIT = 4 * 140 * ITEM_CYCLES_MAX;

	typedef struct {
		value_t candidate;
		logic   is_prime;
	} prime_answer_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	value_t                      candidate = '0;
	logic                        done;
	logic                        is_prime;
	logic                        base_count_wr_en = 1'b0;
	logic [BASE_COUNT_WIDTH-1:0] base_count_wr_data = '0;

	// answers owed by the core, oldest first
	prime_answer_t               pending_answers[$];
	// testbench copy of the witness count register
	logic [BASE_COUNT_WIDTH-1:0] base_count_shadow = BASE_COUNT_RESET;
	int                          error_count = 0;
	longint                      cycle_count = 0;
	// beats left in the current sender burst before a gap
	int                          burst_left = 0;

	miller_rabin_primality_test_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.candidate          (candidate),
		.done               (done),
		.is_prime           (is_prime),
		.base_count_wr_en   (base_count_wr_en),
		.base_count_wr_data (base_count_wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// primality predictor
	// ---------------------------------------------------------------

	// exact (a * b) mod m on a double-width product, same value as shift-and-add
	function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		prod = prod % {64'd0, m};
		return prod[63:0];
	endfunction

	// g^e mod m for m > 1
	function automatic logic [63:0] mod_pow(logic [63:0] g, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = g % m;
		while (e != 64'd0) begin
			if (e[0])
				acc = mod_mul(acc, sq, m);
			sq = mod_mul(sq, sq, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic mr_is_prime(value_t cand, logic [BASE_COUNT_WIDTH-1:0] bases);
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] w;
		logic        hit;
		int          k;
		int          limit;
		n = '0;
		n[VALUE_WIDTH-1:0] = cand;
		if (n < 64'd2)
			return 1'b0;
		if (n == 64'd2)
			return 1'b1;
		if (!n[0])
			return 1'b0;
		// n-1 = d * 2^k
		d = n - 64'd1;
		k = 0;
		while (!d[0]) begin
			d = d >> 1;
			k++;
		end
		// counts above the table size use the whole table
		limit = (bases > BASE_TABLE_SIZE) ? int'(BASE_TABLE_SIZE) : int'(bases);
		for (int i = 0; i < limit; i++) begin
			w = 64'(WITNESS_LIST[i]);
			// testing stops at the first base not below n
			if (w >= n)
				return 1'b1;
			x = mod_pow(w, d, n);
			if (x != 64'd1) begin
				hit = (x == n - 64'd1);
				for (int j = 1; j < k && !hit; j++) begin
					x = mod_mul(x, x, n);
					hit = (x == n - 64'd1);
				end
				if (!hit)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// result checker: done is a one-cycle strobe, no back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		prime_answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("is_prime: unexpected result %0b with nothing pending", is_prime);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (is_prime !== want.is_prime) begin
					$error("is_prime: expected %0b, actual %0b (candidate %0d)",
						want.is_prime, is_prime, want.candidate);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// one beat: hold start until the core takes it, then maybe idle a while.
	// start stays high into the next beat when the burst goes on
	task automatic send_candidate(value_t value);
		prime_answer_t entry;
		int            gap;
		start <= 1'b1;
		candidate <= value;
		do
			@(posedge clk);
		while (busy);
		entry.candidate = value;
		entry.is_prime = mr_is_prime(value, base_count_shadow);
		pending_answers.push_back(entry);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			// mostly short gaps, now and then a long one
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			// long bursts give stretches with no idling at all
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
		end
	endtask

	// let the core run dry before touching the register
	task automatic drain;
		start <= 1'b0;
		while (pending_answers.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base_count(logic [BASE_COUNT_WIDTH-1:0] value);
		drain();
		base_count_wr_en <= 1'b1;
		base_count_wr_data <= value;
		@(posedge clk);
		base_count_wr_en <= 1'b0;
		base_count_shadow = value;
	endtask

	function automatic value_t random_candidate();
		int     sel;
		value_t v;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			// small odd values, dense in primes so most bases get exercised
			v = value_t'($urandom_range(0, 4095) | 1);
		end else if (sel < 50) begin
			// tiny values of either parity, including the trivial answers
			v = value_t'($urandom_range(0, 255));
		end else if (sel < 68) begin
			// x * 2^s + 1: long runs of squarings
			v = (value_t'($urandom_range(1, 255)) << $urandom_range(1, 24)) + value_t'(1);
		end else if (sel < 88) begin
			// medium odd values
			v = value_t'({$urandom, 1'b1});
		end else begin
			// full width, every bit free
			v = value_t'({$urandom, $urandom});
		end
		return v;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// register left at its reset count: trivial answers, field extremes,
	// big primes and composites
	task automatic test_reset_count;
		send_candidate(value_t'(0));
		send_candidate(value_t'(1));
		send_candidate(value_t'(2));
		send_candidate(value_t'(3));
		send_candidate(value_t'(4));
		send_candidate(value_t'(9));
		send_candidate(value_t'(37));
		send_candidate(value_t'(41));
		send_candidate(value_t'(561));
		send_candidate(value_t'(64'd1000000007));
		send_candidate('1);
		send_candidate('1 - value_t'(1));
		send_candidate(value_t'(64'd2305843009213693951));
		send_candidate(value_t'(64'd4611686018427387847));
	endtask

	// no witness at all: every odd value of at least 3 reads as prime
	task automatic test_no_witness;
		write_base_count('0);
		send_candidate(value_t'(9));
		send_candidate(value_t'(561));
		send_candidate(value_t'(4));
		send_candidate(value_t'(1));
		send_candidate(value_t'(3));
	endtask

	// base 2 only: strong pseudoprime to base 2 slips through
	task automatic test_single_witness;
		write_base_count(BASE_COUNT_WIDTH'(1));
		send_candidate(value_t'(2047));
		send_candidate(value_t'(25));
		send_candidate(value_t'(5));
	endtask

	// pseudoprime to the first nine bases, which pass it as prime with nine witnesses
	task automatic test_nine_witnesses;
		write_base_count(BASE_COUNT_WIDTH'(9));
		send_candidate(value_t'(64'd3825123056546413051));
		send_candidate(value_t'(64'd3215031751));
	endtask

	// counts above the table size behave as the whole table
	task automatic test_count_saturation;
		write_base_count('1);
		send_candidate(value_t'(64'd3825123056546413051));
		send_candidate(value_t'(39));
		write_base_count(BASE_TABLE_SIZE + BASE_COUNT_WIDTH'(1));
		send_candidate(value_t'(41));
		write_base_count(BASE_TABLE_SIZE);
		send_candidate(value_t'(37));
	endtask

	// random candidates in phases, each phase with its own witness count
	task automatic test_random_phases;
		for (int phase = 0; phase < 5; phase++) begin
			if (phase == 0)
				write_base_count(BASE_COUNT_RESET);
			else
				write_base_count(BASE_COUNT_WIDTH'($urandom_range(0, 15)));
			for (int n = 0; n < 15; n++)
				send_candidate(random_candidate());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_count();
		test_no_witness();
		test_single_witness();
		test_nine_witnesses();
		test_count_saturation();
		test_random_phases();

		// wait out the last answers, then watch for stray strobes
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
